@@ src/segment_map_unit_with_prom_overlay_top_macros.svh @@
// Assertion macros for the segment map unit.
// Depends on nothing; included by the top level.
`ifndef SEGMENT_MAP_UNIT_WITH_PROM_OVERLAY_TOP_MACROS_SVH
`define SEGMENT_MAP_UNIT_WITH_PROM_OVERLAY_TOP_MACROS_SVH

// same-cycle implication
`define SMU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("segment map unit: same-cycle check failed");

// next-cycle implication
`define SMU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("segment map unit: next-cycle check failed");

`endif

@@ src/smu_pkg.sv @@
// Shared types and constants of the segment map unit.
// No dependencies.
`timescale 1ns / 1ps

package smu_pkg;

    localparam int SEGMENTS_PER_BLOCK  = 16;
    localparam int BLOCK_COUNT_DEF     = 16;
    localparam int MODULE_COUNT        = 16;
    localparam int SEGMENTS_PER_MODULE = 16;
    localparam int CNT_W               = 5;
    // map entry: valid bit, module nibble, segment nibble
    localparam int ENTRY_W             = 9;

    localparam logic [3:0] PROM_BLOCK   = 4'd0;
    localparam logic [3:0] PROM_SEGMENT = 4'd15;

    // register word index
    localparam logic REG_MODULE_COUNT = 1'b0;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_MAP    = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_PROM   = 2'd1,
        KIND_MAPPED = 2'd2,
        KIND_ACK    = 2'd3
    } t_kind;

    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_issue;

endpackage

@@ src/smu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module smu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/smu_ctrl.sv @@
// Request decode, map RAM write side with clearing sweep, PROM and config-done flags.
// Depends on smu_pkg; drives the write side of the map RAM.
`timescale 1ns / 1ps

module smu_ctrl #(
    parameter int BLOCK_COUNT = smu_pkg::BLOCK_COUNT_DEF,
    localparam int DEPTH = BLOCK_COUNT * smu_pkg::SEGMENTS_PER_BLOCK,
    localparam int IW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [1:0]                  i_req_type,
    input  logic [3:0]                  i_block_nb,
    input  logic [3:0]                  i_segment_ab,
    input  logic [3:0]                  i_phys_module,
    input  logic [3:0]                  i_phys_segment,
    input  logic                        i_flag_free,
    input  logic                        i_flag_prom_hide,
    input  logic                        i_flag_prom_show,
    input  logic                        i_flag_config_done,
    input  logic [smu_pkg::CNT_W-1:0]   i_module_count,
    output smu_pkg::t_issue             o_issue,
    output logic                        o_busy,
    output logic                        o_ram_we,
    output logic [IW-1:0]               o_ram_addr,
    output logic [smu_pkg::ENTRY_W-1:0] o_ram_wdata
);

    logic             r_sweep;
    logic [IW-1:0]    r_sweep_addr;
    logic             r_prom_hidden;
    logic             r_config_done;

    logic             in_range;
    logic [7:0]       full_idx;
    logic [IW-1:0]    idx;
    logic             entry_ok;
    logic             is_prom;
    smu_pkg::t_req    req;
    smu_pkg::t_kind   kind;

    assign req      = smu_pkg::t_req'(i_req_type);
    assign in_range = {1'b0, i_block_nb} < 5'(BLOCK_COUNT);
    assign full_idx = {i_block_nb, i_segment_ab};
    assign idx      = full_idx[IW-1:0];
    assign is_prom  = (i_block_nb == smu_pkg::PROM_BLOCK)
                   && (i_segment_ab == smu_pkg::PROM_SEGMENT) && !r_prom_hidden;

    assign entry_ok = !i_flag_free && (i_module_count != '0)
        && ({1'b0, i_phys_module} >= (5'(smu_pkg::MODULE_COUNT) - i_module_count))
        && ({1'b0, i_phys_module} < 5'(smu_pkg::MODULE_COUNT))
        && ({1'b0, i_phys_segment} < 5'(smu_pkg::SEGMENTS_PER_MODULE));

    always_comb begin
        unique case (req)
            smu_pkg::REQ_LOOKUP: begin
                if (is_prom) begin
                    kind = (i_module_count != '0) ? smu_pkg::KIND_PROM : smu_pkg::KIND_NONE;
                end else if (r_config_done && in_range) begin
                    // confirmed by the entry valid bit in the read stage
                    kind = smu_pkg::KIND_MAPPED;
                end else begin
                    kind = smu_pkg::KIND_NONE;
                end
            end
            smu_pkg::REQ_MAP:   kind = smu_pkg::KIND_ACK;
            smu_pkg::REQ_CLEAR: kind = smu_pkg::KIND_ACK;
            default:            kind = smu_pkg::KIND_NONE;
        endcase
    end

    assign o_issue.valid = i_accept;
    assign o_issue.kind  = kind;
    assign o_busy        = r_sweep;
    assign o_ram_we      = r_sweep || (i_accept && (req == smu_pkg::REQ_MAP) && in_range);
    assign o_ram_addr    = r_sweep ? r_sweep_addr : idx;
    assign o_ram_wdata   = r_sweep ? '0 : {entry_ok, i_phys_module, i_phys_segment};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep       <= 1'b1;
            r_sweep_addr  <= '0;
            r_prom_hidden <= 1'b0;
            r_config_done <= 1'b0;
        end else if (r_sweep) begin
            r_sweep_addr <= r_sweep_addr + IW'(1);
            if (r_sweep_addr == IW'(DEPTH - 1)) begin
                r_sweep <= 1'b0;
            end
        end else if (i_accept) begin
            if (req == smu_pkg::REQ_MAP) begin
                if (i_flag_prom_show) begin
                    r_prom_hidden <= 1'b0;
                end else if (i_flag_prom_hide) begin
                    r_prom_hidden <= 1'b1;
                end
                if (i_flag_config_done) begin
                    r_config_done <= 1'b1;
                end
            end else if (req == smu_pkg::REQ_CLEAR) begin
                r_sweep       <= 1'b1;
                r_sweep_addr  <= '0;
                r_prom_hidden <= 1'b0;
            end
        end
    end

endmodule

@@ src/smu_pipe.sv @@
// Read-data stage and output register with stall handling.
// Depends on smu_pkg; takes the registered read data of the map RAM.
`timescale 1ns / 1ps

module smu_pipe (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  smu_pkg::t_issue             i_issue,
    input  logic [smu_pkg::ENTRY_W-1:0] i_rdata,
    input  logic                        i_ready,
    output logic                        o_in_ready,
    output logic                        o_valid,
    output logic [1:0]                  o_result_kind,
    output logic [3:0]                  o_out_module,
    output logic [3:0]                  o_out_segment
);

    logic           r_s1_valid;
    smu_pkg::t_kind r_s1_kind;
    logic           r_o_valid;
    smu_pkg::t_kind r_o_kind;
    logic [3:0]     r_o_module;
    logic [3:0]     r_o_segment;
    logic           load;
    logic           mapped;
    logic           miss;

    assign load   = r_s1_valid && (!r_o_valid || i_ready);
    assign mapped = (r_s1_kind == smu_pkg::KIND_MAPPED) && i_rdata[smu_pkg::ENTRY_W-1];
    assign miss   = (r_s1_kind == smu_pkg::KIND_MAPPED) && !i_rdata[smu_pkg::ENTRY_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_issue.valid) begin
                r_s1_valid <= 1'b1;
            end else if (load) begin
                r_s1_valid <= 1'b0;
            end
            if (load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_issue.valid) begin
            r_s1_kind <= i_issue.kind;
        end
        if (load) begin
            r_o_kind    <= miss ? smu_pkg::KIND_NONE : r_s1_kind;
            r_o_module  <= mapped ? i_rdata[7:4] : 4'd0;
            r_o_segment <= mapped ? i_rdata[3:0] : 4'd0;
        end
    end

    assign o_in_ready    = !r_s1_valid || load;
    assign o_valid       = r_o_valid;
    assign o_result_kind = 2'(r_o_kind);
    assign o_out_module  = r_o_module;
    assign o_out_segment = r_o_segment;

endmodule

@@ src/segment_map_unit_with_prom_overlay_top.sv @@
// Segment map unit with PROM overlay: top level, register port, map RAM.
// Depends on smu_pkg, smu_ram, smu_ctrl, smu_pipe and the macros header.
//
// Usage:
//   Requests enter on i_valid/o_ready with one field per port; each request
//   yields exactly one result on o_valid/i_ready. Lookups translate a
//   logical block and segment, map commands write one entry and the flags,
//   clear requests empty the map and show the PROM.
//   A result passes the map RAM read, then the output register, to o_valid.
//   One lookup or map command per cycle sustained while results are taken
//   and no sweep runs; the single map RAM port pair (one write, one
//   registered read) sets that. A clear request is acknowledged at once,
//   then sweeps the map RAM one entry per cycle with o_ready low until all
//   BLOCK_COUNT*16 entries (256 by default) are clear. The module count
//   register sits at byte address 0 of the APB port; the user must write it
//   only while the unit is idle, which the block itself does not enforce.
//   Reset (synchronous, active low) shows the PROM, clears config-done and
//   the module count, then runs the same sweep before o_ready rises.
//   When the receiver stalls, the result holds in the output register, one
//   more request is taken into the read stage, then o_ready drops.
`timescale 1ns / 1ps

`include "segment_map_unit_with_prom_overlay_top_macros.svh"

module segment_map_unit_with_prom_overlay_top #(
    parameter int BLOCK_COUNT = smu_pkg::BLOCK_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [3:0]  i_block_nb,
    input  logic [3:0]  i_segment_ab,
    input  logic [3:0]  i_phys_module,
    input  logic [3:0]  i_phys_segment,
    input  logic        i_flag_free,
    input  logic        i_flag_prom_hide,
    input  logic        i_flag_prom_show,
    input  logic        i_flag_config_done,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_result_kind,
    output logic [3:0]  o_out_module,
    output logic [3:0]  o_out_segment,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH = BLOCK_COUNT * smu_pkg::SEGMENTS_PER_BLOCK;
    localparam int IW    = $clog2(DEPTH);

    logic [smu_pkg::CNT_W-1:0]   r_module_count;
    logic [smu_pkg::CNT_W-1:0]   count_sat;
    logic                        cfg_write;
    logic                        reg_sel;
    logic                        accept;
    logic                        pipe_ready;
    logic                        busy;
    smu_pkg::t_issue             issue;
    logic                        ram_we;
    logic [IW-1:0]               ram_addr;
    logic [smu_pkg::ENTRY_W-1:0] ram_wdata;
    logic [smu_pkg::ENTRY_W-1:0] ram_rdata;

    assign pready    = 1'b1;
    assign reg_sel   = (paddr[2] == smu_pkg::REG_MODULE_COUNT);
    assign cfg_write = psel && penable && pwrite && pready && reg_sel;
    assign prdata    = reg_sel ? {27'd0, r_module_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_module_count <= '0;
        end else if (cfg_write) begin
            r_module_count <= pwdata[smu_pkg::CNT_W-1:0];
        end
    end

    assign count_sat = (r_module_count > 5'(smu_pkg::MODULE_COUNT))
                     ? 5'(smu_pkg::MODULE_COUNT) : r_module_count;

    assign o_ready = pipe_ready && !busy;
    assign accept  = i_valid && o_ready;

    smu_ctrl #(
        .BLOCK_COUNT(BLOCK_COUNT)
    ) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_req_type         (i_req_type),
        .i_block_nb         (i_block_nb),
        .i_segment_ab       (i_segment_ab),
        .i_phys_module      (i_phys_module),
        .i_phys_segment     (i_phys_segment),
        .i_flag_free        (i_flag_free),
        .i_flag_prom_hide   (i_flag_prom_hide),
        .i_flag_prom_show   (i_flag_prom_show),
        .i_flag_config_done (i_flag_config_done),
        .i_module_count     (count_sat),
        .o_issue            (issue),
        .o_busy             (busy),
        .o_ram_we           (ram_we),
        .o_ram_addr         (ram_addr),
        .o_ram_wdata        (ram_wdata)
    );

    smu_ram #(
        .WIDTH(smu_pkg::ENTRY_W),
        .DEPTH(DEPTH)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    smu_pipe u_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_issue       (issue),
        .i_rdata       (ram_rdata),
        .i_ready       (i_ready),
        .o_in_ready    (pipe_ready),
        .o_valid       (o_valid),
        .o_result_kind (o_result_kind),
        .o_out_module  (o_out_module),
        .o_out_segment (o_out_segment)
    );

    `SMU_ASSERT_IMP(a_zero_unless_mapped, i_clk, i_rst_n,
        o_valid && (o_result_kind != 2'(smu_pkg::KIND_MAPPED)),
        (o_out_module == 4'd0) && (o_out_segment == 4'd0))

    `SMU_ASSERT_IMP(a_stall_only_when_full, i_clk, i_rst_n,
        !o_ready, busy || (o_valid && !i_ready))

    `SMU_ASSERT_IMP(a_write_only_on_map, i_clk, i_rst_n,
        ram_we, busy || (accept && (i_req_type == 2'(smu_pkg::REQ_MAP))))

    `SMU_ASSERT_NEXT(a_clear_blocks_input, i_clk, i_rst_n,
        accept && (i_req_type == 2'(smu_pkg::REQ_CLEAR)), !o_ready)

endmodule
